[rtl/battery_link_health_supervisor_assert.svh]
// Assertion macros shared by the supervisor RTL.
`ifndef BATTERY_LINK_HEALTH_SUPERVISOR_ASSERT_SVH
`define BATTERY_LINK_HEALTH_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLHS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("supervisor check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BLHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("supervisor check failed one cycle later");

`endif

[rtl/blhs_pkg.sv]
`default_nettype none

package blhs_pkg;

  // Widths of the item fields.
  localparam int TIME_W     = 32;
  localparam int KIND_FLD_W = 3;
  localparam int SEV_W      = 26;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int STATE_W    = 2;

  // Alarm layout.
  localparam int ALARM_FIELDS    = 13;
  localparam int WARN_W          = ALARM_FIELDS;
  localparam int FAULT_W         = ALARM_FIELDS + 1;
  localparam int OFFLINE_BIT_IDX = ALARM_FIELDS;
  localparam logic [FAULT_W-1:0] OFFLINE_MASK = 14'h2000;
  localparam logic [FAULT_W-1:0] TRIP_MASK    = 14'h225C;

  // Frame kinds.
  localparam int FRAME_TYPES_DEFAULT = 8;
  localparam int TIMED_KINDS         = 5;
  localparam logic [KIND_FLD_W-1:0] KIND_ST1      = 3'd0;
  localparam logic [KIND_FLD_W-1:0] KIND_CELLVOLT = 3'd2;
  localparam logic [KIND_FLD_W-1:0] KIND_ALARM    = 3'd5;

  // Operation codes carried in tuser.
  localparam logic OPC_FRAME = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  // Supervisor state codes.
  localparam logic [STATE_W-1:0] ST_OFFLINE = 2'd0;
  localparam logic [STATE_W-1:0] ST_ONLINE  = 2'd1;
  localparam logic [STATE_W-1:0] ST_FAULT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TMO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TMO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_ST1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_ST2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_CELLV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_CELLT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_CHGREQ  = 3'd6;

  // Register reset values.
  localparam logic [TMO_W-1:0] RST_OFFLINE_TMO  = 16'd1000;
  localparam logic [TMO_W-1:0] RST_HOLD_TMO     = 16'd1000;
  localparam logic [TMO_W-1:0] RST_STALE_ST1    = 16'd200;
  localparam logic [TMO_W-1:0] RST_STALE_ST2    = 16'd1000;
  localparam logic [TMO_W-1:0] RST_STALE_CELLV  = 16'd500;
  localparam logic [TMO_W-1:0] RST_STALE_CELLT  = 16'd2000;
  localparam logic [TMO_W-1:0] RST_STALE_CHGREQ = 16'd2000;

  // Stream widths.
  localparam int IN_TDATA_W  = 64;
  localparam int RESULT_W    = 34;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [SEV_W-1:0]      alarm_severities;
    logic [KIND_FLD_W-1:0] frame_kind;
    logic [TIME_W-1:0]     now_ms;
    logic                  opcode;
  } item_t;

  // Packed so that link_state sits in the lowest bits.
  typedef struct packed {
    logic               precharge_fresh;
    logic               relay_permit;
    logic               critical_alarm;
    logic [WARN_W-1:0]  warning_vector;
    logic [FAULT_W-1:0] fault_vector;
    logic               data_stale;
    logic               link_online;
    logic [STATE_W-1:0] link_state;
  } result_t;

  // Wrapping difference, negative results count as zero.
  function automatic logic [TIME_W-1:0] elapsed_ms(input logic [TIME_W-1:0] now_t,
                                                   input logic [TIME_W-1:0] then_t);
    logic [TIME_W-1:0] d;
    d = now_t - then_t;
    return d[TIME_W-1] ? '0 : d;
  endfunction

endpackage

`default_nettype wire

[rtl/battery_link_health_supervisor.sv]
// Battery link health supervisor.
// Input stream (s_*): one transaction per event. tuser selects a received frame
// (0) or a periodic evaluation (1); tdata carries the timestamp, frame kind and
// packed alarm severities. Every transaction yields exactly one result on the
// output stream (m_*): link state, online and stale flags, fault and warning
// vectors, critical alarm, relay permission and precharge freshness.
// Configuration (cfg_*): index and 16-bit data, always ready, one register per
// transaction; write only while no event is in flight.
// Pipeline: an accepted transaction passes the input register, then the update
// logic into the output register, which presents its result on m_tvalid and
// m_tdata. Throughput: one transaction per cycle while m_tready is high; the
// stored arrival times are compared against the event timestamp in parallel
// within the single update stage.
// Reset clears the supervisor to offline with no frames seen and no flags, and
// loads the default timeouts. The output stream holds its result while m_tready
// is low; the input register still takes one more transaction, after which
// s_tready drops until the output drains.
`default_nettype none
`include "battery_link_health_supervisor_assert.svh"

module battery_link_health_supervisor #(
  parameter int FRAME_TYPES = blhs_pkg::FRAME_TYPES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // now_ms [31:0], frame_kind [34:32], alarm_severities [60:35], zero [63:61]
  input  wire logic [blhs_pkg::IN_TDATA_W-1:0]    s_tdata,
  // opcode [0]
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // link_state [1:0], link_online [2], data_stale [3], fault_vector [17:4],
  // warning_vector [30:18], critical_alarm [31], relay_permit [32],
  // precharge_fresh [33], zero [39:34]
  output logic [blhs_pkg::OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [blhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [blhs_pkg::TMO_W-1:0]         cfg_data
);
  import blhs_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_fire;
  logic    load_ok;
  result_t result;
  result_t m_view;
  logic    view_up;
  logic    view_relay_ok;

  // An item moves into the output register when that register is free.
  assign item_fire = item_valid && load_ok;

  blhs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (item_fire),
    .item       (item),
    .item_valid (item_valid)
  );

  blhs_core #(
    .FRAME_TYPES (FRAME_TYPES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_fire (item_fire),
    .item      (item),
    .result    (result)
  );

  blhs_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (item_fire),
    .result   (result),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Field view of the outgoing transaction for the checks below.
  assign m_view        = result_t'(m_tdata[RESULT_W-1:0]);
  assign view_up       = (m_view.link_state != ST_OFFLINE);
  assign view_relay_ok = m_view.link_online && !m_view.critical_alarm;

  // Every item that leaves the input register produces a result next cycle.
  `BLHS_ASSERT_NEXT(a_result_follows_item, clk, rst, item_fire, m_tvalid)
  // The online flag agrees with the supervisor state.
  `BLHS_ASSERT_NOW(a_online_matches_state, clk, rst, m_tvalid, m_view.link_online == view_up)
  // Relays are never permitted offline or with a critical alarm.
  `BLHS_ASSERT_NOW(a_relay_safe, clk, rst, m_tvalid && m_view.relay_permit, view_relay_ok)

endmodule

`default_nettype wire

[rtl/blhs_in_reg.sv]
`default_nettype none

module blhs_in_reg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // now_ms [31:0], frame_kind [34:32], alarm_severities [60:35], zero [63:61]
  input  wire logic [blhs_pkg::IN_TDATA_W-1:0]      s_tdata,
  // opcode [0]
  input  wire logic                                 s_tuser,
  input  wire logic                                 advance,
  output blhs_pkg::item_t                           item,
  output logic                                      item_valid
);
  import blhs_pkg::*;

  localparam int KIND_LSB = TIME_W;
  localparam int SEV_LSB  = TIME_W + KIND_FLD_W;

  logic accept;
  logic item_valid_next;

  // The stage takes a new transaction when empty or when its item moves on.
  assign s_tready = !item_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    item_valid_next = item_valid;
    if (accept) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.opcode           <= s_tuser;
      item.now_ms           <= s_tdata[TIME_W-1:0];
      item.frame_kind       <= s_tdata[KIND_LSB +: KIND_FLD_W];
      item.alarm_severities <= s_tdata[SEV_LSB +: SEV_W];
    end
  end

endmodule

`default_nettype wire

[rtl/blhs_core.sv]
`default_nettype none

module blhs_core #(
  parameter int FRAME_TYPES = blhs_pkg::FRAME_TYPES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [blhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [blhs_pkg::TMO_W-1:0]         cfg_data,
  input  wire logic                               item_fire,
  input  wire blhs_pkg::item_t                    item,
  output blhs_pkg::result_t                       result
);
  import blhs_pkg::*;

  localparam int KIND_W = $clog2(FRAME_TYPES);

  // Configuration registers.
  logic [TMO_W-1:0] offline_tmo;
  logic [TMO_W-1:0] hold_tmo;
  logic [TMO_W-1:0] stale_tmo [TIMED_KINDS];

  // Supervisor state.
  logic [TIME_W-1:0]      arrival [FRAME_TYPES];
  logic [FRAME_TYPES-1:0] seen, seen_next;
  logic [TIME_W-1:0]      last_any, last_any_next;
  logic [STATE_W-1:0]     state, state_next;
  logic [FAULT_W-1:0]     faults, faults_next;
  logic [WARN_W-1:0]      warnings, warnings_next;
  logic                   held, held_next;
  logic                   stale_flag, stale_next;
  logic                   online, online_next;

  // Per-item decode.
  logic                   is_frame;
  logic                   kind_ok;
  logic [KIND_W-1:0]      kind_idx;
  logic [FRAME_TYPES-1:0] kind_bit;
  logic [TIME_W-1:0]      el_any;
  logic [TIME_W-1:0]      el_alarm;
  logic [TIME_W-1:0]      el_timed [TIMED_KINDS];
  logic [TIMED_KINDS-1:0] stale_hit;
  logic                   stale_any;
  logic                   timed_out;
  logic                   hold_expired;
  logic [WARN_W-1:0]      sev_warn;
  logic [ALARM_FIELDS-1:0] sev_fault;
  logic                   hit_st1, hit_cellv;
  logic                   crit;
  logic                   fresh;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline_tmo  <= RST_OFFLINE_TMO;
      hold_tmo     <= RST_HOLD_TMO;
      stale_tmo[0] <= RST_STALE_ST1;
      stale_tmo[1] <= RST_STALE_ST2;
      stale_tmo[2] <= RST_STALE_CELLV;
      stale_tmo[3] <= RST_STALE_CELLT;
      stale_tmo[4] <= RST_STALE_CHGREQ;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFFLINE_TMO:  offline_tmo  <= cfg_data;
        REG_HOLD_TMO:     hold_tmo     <= cfg_data;
        REG_STALE_ST1:    stale_tmo[0] <= cfg_data;
        REG_STALE_ST2:    stale_tmo[1] <= cfg_data;
        REG_STALE_CELLV:  stale_tmo[2] <= cfg_data;
        REG_STALE_CELLT:  stale_tmo[3] <= cfg_data;
        REG_STALE_CHGREQ: stale_tmo[4] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Item decode.
  assign is_frame = (item.opcode == OPC_FRAME);
  assign kind_ok  = (int'(item.frame_kind) < FRAME_TYPES);
  assign kind_idx = KIND_W'(item.frame_kind);
  assign kind_bit = FRAME_TYPES'(1) << kind_idx;

  // Elapsed times against the stored arrivals, all in parallel.
  assign el_any   = elapsed_ms(item.now_ms, last_any);
  assign el_alarm = elapsed_ms(item.now_ms, arrival[KIND_ALARM]);
  assign timed_out    = (el_any >= TIME_W'(offline_tmo));
  assign hold_expired = held && seen[KIND_ALARM] && (el_alarm >= TIME_W'(hold_tmo));

  always_comb begin
    for (int i = 0; i < TIMED_KINDS; i++) begin
      el_timed[i]  = elapsed_ms(item.now_ms, arrival[i]);
      stale_hit[i] = (stale_tmo[i] != '0) && seen[i] &&
                     (el_timed[i] >= TIME_W'(stale_tmo[i]));
    end
  end

  assign stale_any = |stale_hit;

  // Severity decode: one is a warning, two or three a fault.
  always_comb begin
    for (int i = 0; i < ALARM_FIELDS; i++) begin
      sev_warn[i]  = (item.alarm_severities[2*i +: 2] == 2'd1);
      sev_fault[i] = item.alarm_severities[2*i+1];
    end
  end

  // Next state of the supervisor.
  always_comb begin
    seen_next     = seen;
    last_any_next = last_any;
    state_next    = state;
    faults_next   = faults;
    warnings_next = warnings;
    held_next     = held;
    stale_next    = stale_flag;
    online_next   = online;
    if (is_frame) begin
      if (kind_ok) begin
        seen_next     = seen | kind_bit;
        last_any_next = item.now_ms;
        if (item.frame_kind == KIND_ALARM) begin
          held_next     = 1'b1;
          warnings_next = sev_warn;
          faults_next   = {faults[OFFLINE_BIT_IDX], sev_fault};
        end
      end
    end else begin
      if (hold_expired) begin
        held_next     = 1'b0;
        warnings_next = '0;
        faults_next   = faults & OFFLINE_MASK;
      end
      unique case (state)
        ST_OFFLINE: begin
          if ((|seen) && !timed_out) begin
            state_next  = ST_ONLINE;
            online_next = 1'b1;
            stale_next  = 1'b0;
            faults_next = faults_next & ~OFFLINE_MASK;
          end
        end
        default: begin
          if (timed_out) begin
            state_next  = ST_OFFLINE;
            online_next = 1'b0;
            stale_next  = 1'b0;
            faults_next = faults_next | OFFLINE_MASK;
          end else begin
            online_next = 1'b1;
            stale_next  = stale_any;
            if (state == ST_ONLINE) begin
              if ((faults_next & TRIP_MASK) != '0) begin
                state_next = ST_FAULT;
              end
            end else if ((faults_next == '0) && !stale_any) begin
              state_next = ST_ONLINE;
            end
          end
        end
      endcase
    end
  end

  // A frame of the same kind in this transaction makes its elapsed time zero.
  assign hit_st1   = is_frame && (item.frame_kind == KIND_ST1);
  assign hit_cellv = is_frame && (item.frame_kind == KIND_CELLVOLT);

  assign crit  = ((faults_next & TRIP_MASK) != '0);
  assign fresh = seen_next[KIND_ST1] && seen_next[KIND_CELLVOLT] &&
                 (hit_st1 || (el_timed[KIND_ST1] <= TIME_W'(stale_tmo[KIND_ST1]))) &&
                 (hit_cellv ||
                  (el_timed[KIND_CELLVOLT] <= TIME_W'(stale_tmo[KIND_CELLVOLT])));

  always_comb begin
    result.link_state      = state_next;
    result.link_online     = online_next;
    result.data_stale      = stale_next;
    result.fault_vector    = faults_next;
    result.warning_vector  = warnings_next;
    result.critical_alarm  = crit;
    result.relay_permit    = online_next && !crit;
    result.precharge_fresh = fresh;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= '0;
      last_any   <= '0;
      state      <= ST_OFFLINE;
      faults     <= '0;
      warnings   <= '0;
      held       <= 1'b0;
      stale_flag <= 1'b0;
      online     <= 1'b0;
    end else if (item_fire) begin
      seen       <= seen_next;
      last_any   <= last_any_next;
      state      <= state_next;
      faults     <= faults_next;
      warnings   <= warnings_next;
      held       <= held_next;
      stale_flag <= stale_next;
      online     <= online_next;
    end
  end

  // Arrival times hold no reset; each is read only behind its seen bit.
  always_ff @(posedge clk) begin
    if (item_fire && is_frame && kind_ok) begin
      arrival[kind_idx] <= item.now_ms;
    end
  end

endmodule

`default_nettype wire

[rtl/blhs_out_reg.sv]
`default_nettype none

module blhs_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire blhs_pkg::result_t                 result,
  output logic                                   load_ok,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [blhs_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import blhs_pkg::*;

  result_t held_result;
  logic    m_tvalid_next;

  // The register can take a result when empty or being drained.
  assign load_ok = !m_tvalid || m_tready;

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_result <= result;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, held_result};

endmodule

`default_nettype wire
